// ===== rtl/bc13_pkg.sv =====
// Shared types for the BC1/BC3 block decoder: block, texel and palette structs.
`default_nettype none
package bc13_pkg;

  localparam int unsigned TexelsPerBlock = 16;

  // One compressed block as it arrives.
  typedef struct packed {
    logic [63:0] color_word;
    logic [63:0] alpha_word;
  } blk_t;

  // One decoded texel as it leaves.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [3:0] texel_index;
    logic       last_texel;
  } texel_t;

  // Finished palettes and per-texel indices of one block.
  typedef struct packed {
    logic                 bc3;
    logic                 four;
    logic [3:0][2:0][7:0] color;
    logic [7:0][7:0]      apal;
    logic [31:0]          cidx;
    logic [47:0]          aidx;
  } pal_t;

endpackage
`default_nettype wire

// ===== rtl/bc13_palette.sv =====
// Four-stage pipeline that builds the color and alpha palettes of a block.
`default_nettype none
module bc13_palette (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            mode,
  input  wire logic            blk_valid,
  output logic                 blk_stall,
  input  wire bc13_pkg::blk_t  blk,
  output logic                 pal_valid,
  input  wire logic            pal_ready,
  output bc13_pkg::pal_t       pal
);

  // c*255/31 and c*255/63 with truncation, done as reciprocal multiplies.
  function automatic logic [7:0] expand5(input logic [4:0] c);
    logic [26:0] p;
    begin
      p = 27'(c) * 27'd2156535;
      expand5 = p[25:18];
    end
  endfunction

  function automatic logic [7:0] expand6(input logic [5:0] c);
    logic [28:0] p;
    begin
      p = 29'(c) * 29'd4244475;
      expand6 = p[27:20];
    end
  endfunction

  // Stage 1: captured block.
  logic        v1, mode1;
  logic [63:0] cw1, aw1;
  // Stage 2: expanded endpoints and weighted alpha sums.
  logic             v2, mode2, four2, agt2;
  logic [1:0][2:0][7:0] ep2;
  logic [7:0]       a0_2, a1_2;
  logic [5:0][10:0] asum2;
  logic [31:0]      cidx2;
  logic [47:0]      aidx2;
  // Stage 3: color sums and finished alpha palette.
  logic             v3, mode3, four3;
  logic [1:0][2:0][7:0] ep3;
  logic [2:0][9:0]  csum_a3, csum_b3;
  logic [7:0][7:0]  apal3;
  logic [31:0]      cidx3;
  logic [47:0]      aidx3;

  logic ready1, ready2, ready3, ready4;
  logic [1:0][2:0][7:0] ep_next;
  logic [5:0][10:0] asum_next;
  logic [2:0][9:0]  csum_a_next, csum_b_next;
  logic [7:0][7:0]  apal_next;
  logic [3:0][2:0][7:0] color_next;
  logic [22:0]      aprod;
  logic [19:0]      cprod_a, cprod_b;

  assign ready4    = !pal_valid || pal_ready;
  assign ready3    = !v3 || ready4;
  assign ready2    = !v2 || ready3;
  assign ready1    = !v1 || ready2;
  assign blk_stall = !ready1;

  always_comb begin
    for (int e = 0; e < 2; e++) begin
      ep_next[e][0] = expand5(cw1[16*e+11 +: 5]);
      ep_next[e][1] = expand6(cw1[16*e+5 +: 6]);
      ep_next[e][2] = expand5(cw1[16*e +: 5]);
    end
  end

  // Entry j+2 of the alpha palette is a weighted sum of the two endpoints.
  always_comb begin
    for (int j = 0; j < 6; j++) begin
      if (aw1[7:0] > aw1[15:8]) begin
        asum_next[j] = 11'(6 - j) * 11'(aw1[7:0]) + 11'(j + 1) * 11'(aw1[15:8]);
      end else if (j < 4) begin
        asum_next[j] = 11'(4 - j) * 11'(aw1[7:0]) + 11'(j + 1) * 11'(aw1[15:8]);
      end else begin
        asum_next[j] = '0;
      end
    end
  end

  always_comb begin
    aprod = '0;
    apal_next[0] = a0_2;
    apal_next[1] = a1_2;
    for (int j = 0; j < 6; j++) begin
      if (agt2) begin
        aprod = 23'(asum2[j]) * 23'd2341;
        apal_next[j+2] = aprod[21:14];
      end else if (j < 4) begin
        aprod = 23'(asum2[j]) * 23'd3277;
        apal_next[j+2] = aprod[21:14];
      end else if (j == 4) begin
        apal_next[j+2] = 8'd0;
      end else begin
        apal_next[j+2] = 8'd255;
      end
    end
    for (int ch = 0; ch < 3; ch++) begin
      if (four2) begin
        csum_a_next[ch] = 10'({ep2[0][ch], 1'b0}) + 10'(ep2[1][ch]);
      end else begin
        csum_a_next[ch] = 10'(ep2[0][ch]) + 10'(ep2[1][ch]);
      end
      csum_b_next[ch] = 10'(ep2[0][ch]) + 10'({ep2[1][ch], 1'b0});
    end
  end

  // Thirds by reciprocal multiply, halves by shift.
  always_comb begin
    cprod_a = '0;
    cprod_b = '0;
    color_next[0] = ep3[0];
    color_next[1] = ep3[1];
    for (int ch = 0; ch < 3; ch++) begin
      cprod_a = 20'(csum_a3[ch]) * 20'd683;
      cprod_b = 20'(csum_b3[ch]) * 20'd683;
      if (four3) begin
        color_next[2][ch] = cprod_a[18:11];
        color_next[3][ch] = cprod_b[18:11];
      end else begin
        color_next[2][ch] = csum_a3[ch][8:1];
        color_next[3][ch] = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      pal_valid <= 1'b0;
    end else begin
      if (ready1) begin
        v1 <= blk_valid;
      end
      if (ready2) begin
        v2 <= v1;
      end
      if (ready3) begin
        v3 <= v2;
      end
      if (ready4) begin
        pal_valid <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && blk_valid) begin
      mode1 <= mode;
      cw1   <= blk.color_word;
      aw1   <= blk.alpha_word;
    end
    if (ready2 && v1) begin
      mode2 <= mode1;
      four2 <= cw1[15:0] > cw1[31:16];
      agt2  <= aw1[7:0] > aw1[15:8];
      ep2   <= ep_next;
      a0_2  <= aw1[7:0];
      a1_2  <= aw1[15:8];
      asum2 <= asum_next;
      cidx2 <= cw1[63:32];
      aidx2 <= aw1[63:16];
    end
    if (ready3 && v2) begin
      mode3   <= mode2;
      four3   <= four2;
      ep3     <= ep2;
      csum_a3 <= csum_a_next;
      csum_b3 <= csum_b_next;
      apal3   <= apal_next;
      cidx3   <= cidx2;
      aidx3   <= aidx2;
    end
    if (ready4 && v3) begin
      pal.bc3   <= mode3;
      pal.four  <= four3;
      pal.color <= color_next;
      pal.apal  <= apal3;
      pal.cidx  <= cidx3;
      pal.aidx  <= aidx3;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/bc13_serializer.sv =====
// Walks the sixteen texels of a decoded block into an output register.
`default_nettype none
module bc13_serializer (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            pal_valid,
  output logic                 pal_ready,
  input  wire bc13_pkg::pal_t  pal,
  output logic                 texel_valid,
  input  wire logic            texel_stall,
  output bc13_pkg::texel_t     texel
);

  logic           sv;
  bc13_pkg::pal_t sp;
  logic [3:0]     cnt;
  logic           load_out;
  logic           last;
  logic [1:0]     ci;
  logic [2:0]     ai;
  logic [5:0]     abit;
  bc13_pkg::texel_t texel_next;

  assign load_out  = sv && (!texel_valid || !texel_stall);
  assign last      = (cnt == 4'(bc13_pkg::TexelsPerBlock - 1));
  assign pal_ready = !sv || (load_out && last);
  assign abit      = {1'b0, cnt, 1'b0} + {2'b00, cnt};
  assign ci        = sp.cidx[{cnt, 1'b0} +: 2];
  assign ai        = sp.aidx[abit +: 3];

  always_comb begin
    texel_next.red         = sp.color[ci][0];
    texel_next.green       = sp.color[ci][1];
    texel_next.blue        = sp.color[ci][2];
    texel_next.texel_index = cnt;
    texel_next.last_texel  = last;
    // Without BC3 alpha, only the transparent entry of the three-color palette is clear.
    if (sp.bc3) begin
      texel_next.alpha = sp.apal[ai];
    end else if (!sp.four && ci == 2'd3) begin
      texel_next.alpha = 8'd0;
    end else begin
      texel_next.alpha = 8'd255;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sv          <= 1'b0;
      cnt         <= '0;
      texel_valid <= 1'b0;
    end else begin
      if (pal_ready) begin
        sv  <= pal_valid;
        cnt <= '0;
      end else if (load_out) begin
        cnt <= cnt + 4'd1;
      end
      if (load_out) begin
        texel_valid <= 1'b1;
      end else if (!texel_stall) begin
        texel_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pal_ready && pal_valid) begin
      sp <= pal;
    end
    if (load_out) begin
      texel <= texel_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/bc1_bc3_block_decoder.sv =====
// Top level of the BC1/BC3 block decoder: mode register, palette pipeline, texel serializer.
// A block passes palette stages 1 to 4, is loaded into the serializer and leaves through
// the texel register; the serializer takes the next block as it loads the last texel.
// Throughput: one texel per cycle when the output is not stalled, set by the serializer.
// Up to six blocks can be in flight: four palette stages, serializer, texel register.
// Reset (rst, synchronous) empties the pipeline and sets format_mode to BC1.
`default_nettype none
module bc1_bc3_block_decoder (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic             cfg_data,
  input  wire logic             blk_valid,
  output logic                  blk_stall,
  input  wire bc13_pkg::blk_t   blk,
  output logic                  texel_valid,
  input  wire logic             texel_stall,
  output bc13_pkg::texel_t      texel
);

  logic           format_mode;
  logic           pal_valid;
  logic           pal_ready;
  bc13_pkg::pal_t pal;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      format_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      format_mode <= cfg_data;
    end
  end

  bc13_palette u_palette (
    .clk       (clk),
    .rst       (rst),
    .mode      (format_mode),
    .blk_valid (blk_valid),
    .blk_stall (blk_stall),
    .blk       (blk),
    .pal_valid (pal_valid),
    .pal_ready (pal_ready),
    .pal       (pal)
  );

  bc13_serializer u_serializer (
    .clk         (clk),
    .rst         (rst),
    .pal_valid   (pal_valid),
    .pal_ready   (pal_ready),
    .pal         (pal),
    .texel_valid (texel_valid),
    .texel_stall (texel_stall),
    .texel       (texel)
  );

endmodule
`default_nettype wire
